FILE: src/etx_pkg.sv
`default_nettype none

package etx_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_LENGTH       = 2'd0;
    localparam logic [1:0] REG_START_WINDOW_LENGTH = 2'd1;
    localparam logic [1:0] REG_SAMPLE_INTERVAL_MS  = 2'd2;
    localparam logic [1:0] REG_COST_CEILING        = 2'd3;

    // register reset values
    localparam logic [8:0]  WIN_LEN_RST     = 9'd64;
    localparam logic [8:0]  START_WIN_RST   = 9'd4;
    localparam logic [21:0] SAMPLE_INTV_RST = 22'd1000;
    localparam logic [23:0] CEILING_RST     = 24'd65536;

    // action codes
    localparam logic [2:0] ACT_LINK_INIT    = 3'd0;
    localparam logic [2:0] ACT_PACKET       = 3'd1;
    localparam logic [2:0] ACT_HELLO_LOST   = 3'd2;
    localparam logic [2:0] ACT_LINK_CHANGED = 3'd3;
    localparam logic [2:0] ACT_SAMPLE_TICK  = 3'd4;

    // counters and sequence handling
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [15:0] GAP_LIMIT  = 16'd255;
    localparam int          COST_SHIFT = 12;

    // shared arithmetic unit
    localparam int ACC_W     = 80;
    localparam int OPB_W     = 32;
    localparam int STEP_W    = 7;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 80;

    typedef logic t_alu_op;
    localparam t_alu_op ALU_MUL = 1'b0;
    localparam t_alu_op ALU_DIV = 1'b1;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

`default_nettype wire

FILE: src/etx_ram.sv
`default_nettype none

module etx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/etx_alu.sv
`default_nettype none

module etx_alu import etx_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_alu_req         i_req,
    input  wire logic [ACC_W-1:0] i_opa,
    input  wire logic [OPB_W-1:0] i_opb,
    output logic                  o_done,
    output logic      [ACC_W-1:0] o_result
);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [STEP_W-1:0] r_cnt;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_a;
    logic [OPB_W-1:0]  r_b;
    logic [OPB_W-1:0]  r_rem;

    logic [ACC_W-1:0]  mul_next;
    logic [OPB_W:0]    trial;
    logic [OPB_W:0]    diff;
    logic              qbit;
    logic [OPB_W-1:0]  rem_next;

    // shift-add multiply step, msb of multiplier first
    assign mul_next = {r_acc[ACC_W-2:0], 1'b0} + (r_b[OPB_W-1] ? r_a : '0);

    // restoring divide step
    assign trial    = {r_rem, r_acc[ACC_W-1]};
    assign diff     = trial - {1'b0, r_b};
    assign qbit     = ~diff[OPB_W];
    assign rem_next = qbit ? diff[OPB_W-1:0] : trial[OPB_W-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_acc <= (i_req.op == ALU_MUL) ? '0 : i_opa;
            r_a   <= i_opa;
            r_b   <= i_opb;
            r_rem <= '0;
            r_cnt <= (i_req.op == ALU_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_op == ALU_MUL) begin
                r_acc <= mul_next;
                r_b   <= {r_b[OPB_W-2:0], 1'b0};
            end else begin
                r_acc <= {r_acc[ACC_W-2:0], qbit};
                r_rem <= rem_next;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

FILE: src/etx_link_cost_estimator_unit.sv
`default_nettype none

// a packet on an active link steps through a bucket read and a bucket write; link changed and
// hello lost stay idle; a tick strobes its cost after n bucket reads and an 80-step divide
// (with missed hellos first two 32-step multiplies and an 80-step divide for the correction);
// link init clears all WINDOW_MAX buckets; one item at a time; busy is high while an item is in work
// synchronous active-low reset; after reset a bucket clearing pass over WINDOW_MAX buckets runs
// the cost strobe is one cycle wide and cannot be stalled
module etx_link_cost_estimator_unit import etx_pkg::*; #(
    parameter int WINDOW_MAX = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_packet_seq,
    input  wire logic [23:0] i_interval_time_ms,
    input  wire logic [23:0] i_validity_time_ms,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [23:0] i_cfg_wdata,
    output logic             o_valid,
    output logic      [23:0] o_link_cost
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 16 + CW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_PKT_RD   = 4'd2;
    localparam logic [3:0] S_PKT_WR   = 4'd3;
    localparam logic [3:0] S_SUM      = 4'd4;
    localparam logic [3:0] S_SUM_LAST = 4'd5;
    localparam logic [3:0] S_CORR     = 4'd6;
    localparam logic [3:0] S_MUL1     = 4'd7;
    localparam logic [3:0] S_MUL2     = 4'd8;
    localparam logic [3:0] S_DIV1     = 4'd9;
    localparam logic [3:0] S_COST     = 4'd10;
    localparam logic [3:0] S_DIV2     = 4'd11;
    localparam logic [3:0] S_EMIT     = 4'd12;

    // configuration
    logic [8:0]  r_win_len;
    logic [8:0]  r_start_win;
    logic [21:0] r_sample_ms;
    logic [23:0] r_ceiling;

    // link state
    logic        r_active;
    logic [AW-1:0] r_ring;
    logic [8:0]  r_cur_win;
    logic [15:0] r_missed;
    logic [15:0] r_last_seq;
    logic [23:0] r_hello_ms;

    // sequencer
    logic [3:0]    r_state;
    logic [CW-1:0] r_idx;
    logic          r_clr_all;
    logic          r_rd_vld;
    logic [7:0]    r_gap;
    logic [SW-1:0] r_rec;
    logic [63:0]   r_tot;
    logic [31:0]   r_den;
    logic [23:0]   r_cost;
    logic          r_valid;

    logic              accept;
    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     ring_inc;
    logic [AW-1:0]     ring_next;
    logic [15:0]       gap_raw;
    logic [21:0]       sample_eff;
    logic [16:0]       tot_add;
    logic [15:0]       rec_old;
    logic [15:0]       tot_old;
    logic [64:0]       corr_sum;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    t_alu_req          alu_req;
    logic [ACC_W-1:0]  alu_opa;
    logic [OPB_W-1:0]  alu_opb;
    logic              alu_done;
    logic [ACC_W-1:0]  alu_result;

    assign accept = i_start && (r_state == S_IDLE);

    // effective window, clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_win_len == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_win_len) > WINDOW_MAX) begin
            w_eff = CW'(WINDOW_MAX);
        end else begin
            w_eff = CW'(r_win_len);
        end
    end

    // buckets summed on a tick
    assign n_cnt = (32'(r_cur_win) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(r_cur_win);

    // ring advance
    assign ring_inc  = CW'(r_ring) + CW'(1);
    assign ring_next = (ring_inc >= w_eff) ? '0 : AW'(ring_inc);

    // sequence gap and bucket update
    assign gap_raw    = i_packet_seq - r_last_seq;
    assign sample_eff = (r_sample_ms == '0) ? 22'd1 : r_sample_ms;
    assign rec_old    = ram_rdata[31:16];
    assign tot_old    = ram_rdata[15:0];
    assign tot_add    = {1'b0, tot_old} + {9'd0, r_gap};
    assign corr_sum   = {1'b0, r_tot} + {1'b0, alu_result[63:0]};

    // bucket memory: received count high, total count low
    etx_ram #(
        .WIDTH(32),
        .DEPTH(WINDOW_MAX)
    ) u_bucket_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // shared multiply / divide unit
    etx_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_opa   (alu_opa),
        .i_opb   (alu_opb),
        .o_done  (alu_done),
        .o_result(alu_result)
    );

    // memory port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = (r_state == S_PKT_RD) ? r_ring : AW'(r_idx);
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx);
                ram_wdata = {16'd0, 15'd0, (r_clr_all || r_idx < w_eff)};
            end
            S_PKT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ring;
                ram_wdata[31:16] = (rec_old == CNT_MAX) ? CNT_MAX : rec_old + 16'd1;
                ram_wdata[15:0]  = tot_add[16] ? CNT_MAX : tot_add[15:0];
            end
            S_EMIT: begin
                ram_we    = 1'b1;
                ram_waddr = ring_next;
            end
            S_IDLE: begin
                if (accept && i_action == ACT_PACKET && !r_active) begin
                    ram_we    = 1'b1;
                    ram_wdata = {16'd1, 16'd1};
                end
            end
            default: begin
            end
        endcase
    end

    // arithmetic unit requests
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_opa       = '0;
        alu_opb       = '0;
        unique case (r_state)
            S_CORR: begin
                alu_req.start = (r_missed != '0);
                alu_opa       = ACC_W'(r_tot);
                alu_opb       = OPB_W'(r_missed);
            end
            S_MUL1: begin
                alu_req.start = alu_done;
                alu_opa       = alu_result;
                alu_opb       = OPB_W'(r_hello_ms);
            end
            S_MUL2: begin
                alu_req.start = alu_done && (alu_result[ACC_W-1:64] == '0);
                alu_req.op    = ALU_DIV;
                alu_opa       = alu_result;
                alu_opb       = r_den;
            end
            S_COST: begin
                alu_req.start = (r_rec != '0);
                alu_req.op    = ALU_DIV;
                alu_opa       = ACC_W'({r_tot, {COST_SHIFT{1'b0}}});
                alu_opb       = OPB_W'(r_rec);
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= WIN_LEN_RST;
            r_start_win <= START_WIN_RST;
            r_sample_ms <= SAMPLE_INTV_RST;
            r_ceiling   <= CEILING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW_LENGTH:       r_win_len   <= i_cfg_wdata[8:0];
                REG_START_WINDOW_LENGTH: r_start_win <= i_cfg_wdata[8:0];
                REG_SAMPLE_INTERVAL_MS:  r_sample_ms <= i_cfg_wdata[21:0];
                REG_COST_CEILING:        r_ceiling   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer and link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_clr_all  <= 1'b1;
            r_rd_vld   <= 1'b0;
            r_valid    <= 1'b0;
            r_active   <= 1'b0;
            r_ring     <= '0;
            r_cur_win  <= START_WIN_RST;
            r_missed   <= '0;
            r_last_seq <= '0;
            r_hello_ms <= '0;
        end else begin
            r_valid <= 1'b0;

            // bucket sum, one ram read per cycle
            if (r_rd_vld) begin
                r_rec <= r_rec + SW'(rec_old);
                r_tot <= r_tot + 64'(tot_old);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_action)
                            ACT_LINK_INIT: begin
                                r_active   <= 1'b0;
                                r_ring     <= '0;
                                r_cur_win  <= r_start_win;
                                r_missed   <= '0;
                                r_last_seq <= '0;
                                r_hello_ms <= '0;
                                r_idx      <= '0;
                                r_clr_all  <= 1'b0;
                                r_state    <= S_CLEAR;
                            end
                            ACT_PACKET: begin
                                r_last_seq <= i_packet_seq;
                                if (!r_active) begin
                                    r_active <= 1'b1;
                                    r_ring   <= '0;
                                end else begin
                                    r_gap   <= (gap_raw > GAP_LIMIT) ? 8'd1 : gap_raw[7:0];
                                    r_state <= S_PKT_RD;
                                end
                            end
                            ACT_HELLO_LOST: begin
                                if (r_active && r_missed != CNT_MAX) begin
                                    r_missed <= r_missed + 16'd1;
                                end
                            end
                            ACT_LINK_CHANGED: begin
                                r_hello_ms <= (i_interval_time_ms != '0) ?
                                              i_interval_time_ms : i_validity_time_ms;
                                r_missed   <= '0;
                            end
                            ACT_SAMPLE_TICK: begin
                                if (r_active) begin
                                    if (32'(r_cur_win) < 32'(w_eff)) begin
                                        r_cur_win <= r_cur_win + 9'd1;
                                    end
                                    r_den    <= 32'(sample_eff) * 32'(w_eff);
                                    r_rec    <= '0;
                                    r_tot    <= '0;
                                    r_idx    <= '0;
                                    r_rd_vld <= 1'b0;
                                    r_state  <= S_SUM;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == CW'(WINDOW_MAX - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_PKT_RD: begin
                    r_state <= S_PKT_WR;
                end
                S_PKT_WR: begin
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    r_rd_vld <= 1'b1;
                    r_idx    <= r_idx + CW'(1);
                    if (r_idx == n_cnt - CW'(1)) begin
                        r_state <= S_SUM_LAST;
                    end
                end
                S_SUM_LAST: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_CORR;
                end
                S_CORR: begin
                    r_state <= (r_missed != '0) ? S_MUL1 : S_COST;
                end
                S_MUL1: begin
                    if (alu_done) begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (alu_done) begin
                        if (alu_result[ACC_W-1:64] != '0) begin
                            r_tot   <= '1;
                            r_state <= S_COST;
                        end else begin
                            r_state <= S_DIV1;
                        end
                    end
                end
                S_DIV1: begin
                    if (alu_done) begin
                        r_tot   <= corr_sum[64] ? '1 : corr_sum[63:0];
                        r_state <= S_COST;
                    end
                end
                S_COST: begin
                    if (r_rec == '0) begin
                        r_cost  <= r_ceiling;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (alu_done) begin
                        if (alu_result[ACC_W-1:24] != '0 || alu_result[23:0] > r_ceiling) begin
                            r_cost <= r_ceiling;
                        end else begin
                            r_cost <= alu_result[23:0];
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_ring  <= ring_next;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_link_cost = r_cost;

`ifndef NO_ASSERTIONS
    // a cost beat only follows the emit step
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == S_EMIT)
        else $error("cost beat without emit step");

    // the arithmetic unit only finishes while the sequencer waits on it
    a_alu_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_MUL1 || r_state == S_MUL2 ||
                      r_state == S_DIV1 || r_state == S_DIV2))
        else $error("arithmetic result with no waiting step");

    // ring pointer stays inside the bucket memory
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ring) < WINDOW_MAX)
        else $error("ring pointer out of range");

    // an emitted cost never exceeds the ceiling
    a_cost_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_cost <= r_ceiling)
        else $error("cost above ceiling");
`endif

endmodule

`default_nettype wire

FILE: test/tb_etx_link_cost_estimator_unit.sv
module tb_etx_link_cost_estimator_unit;
    import etx_pkg::*;

    localparam int WIN_MAX     = 256;
    localparam int SETTLE_CYC  = 700;
    localparam int STALL_LIMIT = 20000;
    localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_action = '0;
    logic [15:0] i_packet_seq = '0;
    logic [23:0] i_interval_time_ms = '0;
    logic [23:0] i_validity_time_ms = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [23:0] i_cfg_wdata = '0;
    logic        o_busy;
    logic        o_valid;
    logic [23:0] o_link_cost;

    etx_link_cost_estimator_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_action           (i_action),
        .i_packet_seq       (i_packet_seq),
        .i_interval_time_ms (i_interval_time_ms),
        .i_validity_time_ms (i_validity_time_ms),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_link_cost        (o_link_cost)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the registers and link state
    logic [8:0]  win_len_reg   = WIN_LEN_RST;
    logic [8:0]  start_win_reg = START_WIN_RST;
    logic [21:0] sample_ms_reg = SAMPLE_INTV_RST;
    logic [23:0] ceiling_reg   = CEILING_RST;

    bit          link_up;
    int          ring_pos;
    int          cur_win;
    int          lost_hello_cnt;
    int          prev_seq;
    int          hello_ms;
    int          rx_cnt [WIN_MAX];
    int          tot_cnt [WIN_MAX];

    logic [23:0] cost_q[$];
    int          err_cnt = 0;
    int          idle_pct = 0;
    logic [15:0] seq_cursor = '0;
    bit          start_hold = 1'b0;

    function automatic int clamp_window();
        int w;
        w = win_len_reg;
        if (w < 1) w = 1;
        if (w > WIN_MAX) w = WIN_MAX;
        return w;
    endfunction

    function automatic int add_sat16(int a, int b);
        return (a + b > 65535) ? 65535 : a + b;
    endfunction

    task automatic clear_link_state();
        int w;
        w = clamp_window();
        link_up = 1'b0;
        ring_pos = 0;
        cur_win = start_win_reg;
        lost_hello_cnt = 0;
        prev_seq = 0;
        hello_ms = 0;
        for (int i = 0; i < WIN_MAX; i++) begin
            rx_cnt[i] = 0;
            tot_cnt[i] = (i < w) ? 1 : 0;
        end
    endtask

    // etx ratio over the current window with missed hello correction
    task automatic window_cost(output logic [23:0] cost);
        int w, n;
        longint unsigned rec, tot, a, den, corr, q, r, c;
        w = clamp_window();
        rec = 0;
        tot = 0;
        if (cur_win < w) cur_win++;
        n = (cur_win > WIN_MAX) ? WIN_MAX : cur_win;
        for (int i = 0; i < n; i++) begin
            rec += rx_cnt[i];
            tot += tot_cnt[i];
        end
        if (lost_hello_cnt > 0) begin
            a = tot * longint'(lost_hello_cnt);
            den = longint'((sample_ms_reg == 0) ? 1 : sample_ms_reg) * longint'(w);
            if (hello_ms != 0 && a > U64_MAX / longint'(hello_ms)) begin
                tot = U64_MAX;
            end else begin
                corr = (a * longint'(hello_ms)) / den;
                tot = (tot > U64_MAX - corr) ? U64_MAX : tot + corr;
            end
        end
        if (rec == 0) begin
            cost = ceiling_reg;
        end else begin
            q = tot / rec;
            if (q >= 64'd65536) begin
                cost = ceiling_reg;
            end else begin
                r = tot % rec;
                c = q * 4096 + (r * 4096) / rec;
                if (c > ceiling_reg) c = ceiling_reg;
                cost = c[23:0];
            end
        end
    endtask

    task automatic predict_beat(input logic [2:0] act, input logic [15:0] seq,
                                input logic [23:0] itime, input logic [23:0] vtime);
        int gap, w;
        logic [23:0] cost;
        case (act)
            ACT_LINK_INIT: clear_link_state();
            ACT_PACKET: begin
                if (!link_up) begin
                    link_up = 1'b1;
                    ring_pos = 0;
                    rx_cnt[0] = 1;
                    tot_cnt[0] = 1;
                end else begin
                    gap = (int'(seq) - prev_seq) & 16'hFFFF;
                    if (gap > GAP_LIMIT) gap = 1;
                    rx_cnt[ring_pos] = add_sat16(rx_cnt[ring_pos], 1);
                    tot_cnt[ring_pos] = add_sat16(tot_cnt[ring_pos], gap);
                end
                prev_seq = seq;
            end
            ACT_HELLO_LOST: begin
                if (link_up && lost_hello_cnt < CNT_MAX) lost_hello_cnt++;
            end
            ACT_LINK_CHANGED: begin
                hello_ms = (itime != 0) ? itime : vtime;
                lost_hello_cnt = 0;
            end
            ACT_SAMPLE_TICK: begin
                if (link_up) begin
                    window_cost(cost);
                    cost_q.push_back(cost);
                    w = clamp_window();
                    ring_pos++;
                    if (ring_pos >= w) ring_pos = 0;
                    rx_cnt[ring_pos] = 0;
                    tot_cnt[ring_pos] = 0;
                end
            end
            default: ;
        endcase
    endtask

    // send one beat and hold it until the block takes it
    task automatic send_beat(input logic [2:0] act, input logic [15:0] seq,
                             input logic [23:0] itime, input logic [23:0] vtime);
        start_hold = 1'b1;
        i_start <= 1'b1;
        i_action <= act;
        i_packet_seq <= seq;
        i_interval_time_ms <= itime;
        i_validity_time_ms <= vtime;
        do @(posedge i_clk); while (o_busy);
        predict_beat(act, seq, itime, vtime);
        if ($urandom_range(99) < idle_pct) begin
            start_hold = 1'b0;
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // sender pauses until every expected cost has come and the block settles
    task automatic drain();
        if (start_hold) begin
            start_hold = 1'b0;
            i_start <= 1'b0;
        end
        while (cost_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_regs(input int win, input int swin, input int sms, input int ceil);
        logic [23:0] vals [4];
        vals = '{24'(win), 24'(swin), 24'(sms), 24'(ceil)};
        drain();
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= i[1:0];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            case (i[1:0])
                REG_WINDOW_LENGTH:       win_len_reg = vals[i][8:0];
                REG_START_WINDOW_LENGTH: start_win_reg = vals[i][8:0];
                REG_SAMPLE_INTERVAL_MS:  sample_ms_reg = vals[i][21:0];
                REG_COST_CEILING:        ceiling_reg = vals[i];
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_packet_inc(input int step);
        seq_cursor = seq_cursor + step[15:0];
        send_beat(ACT_PACKET, seq_cursor, 24'($urandom), 24'($urandom));
    endtask

    // inactive link, sequence gaps, wrap, hello handling, unknown actions
    task automatic test_directed();
        write_regs(WIN_LEN_RST, START_WIN_RST, SAMPLE_INTV_RST, CEILING_RST);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
        send_beat(ACT_HELLO_LOST, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_beat(ACT_LINK_INIT, '0, '0, '0);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
        seq_cursor = 16'hFF00;
        send_beat(ACT_PACKET, seq_cursor, '0, '0);
        send_packet_inc(1);
        send_packet_inc(255);
        send_packet_inc(256);
        send_packet_inc(0);
        seq_cursor = 16'hFFFF;
        send_beat(ACT_PACKET, seq_cursor, '0, '0);
        send_packet_inc(1);
        send_beat(ACT_SAMPLE_TICK, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_beat(ACT_LINK_CHANGED, '0, 24'd0, 24'hFFFFFF);
        send_beat(ACT_HELLO_LOST, '0, '0, '0);
        send_beat(ACT_HELLO_LOST, '0, '0, '0);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
        send_beat(ACT_LINK_CHANGED, '0, 24'hFFFFFF, 24'd5);
        send_beat(ACT_HELLO_LOST, '0, '0, '0);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
        send_beat(3'd5, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_beat(3'd6, '0, '0, '0);
        send_beat(3'd7, 16'hAAAA, 24'h555555, 24'hAAAAAA);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
    endtask

    // bucket totals run into saturation, large hello correction
    task automatic test_saturation();
        write_regs(2, 1, 100, 24'hFFFFFF);
        send_beat(ACT_LINK_INIT, '0, '0, '0);
        seq_cursor = '0;
        send_beat(ACT_PACKET, seq_cursor, '0, '0);
        for (int i = 0; i < 300; i++) send_packet_inc(255);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
        send_beat(ACT_LINK_CHANGED, '0, 24'hFFFFFF, '0);
        for (int i = 0; i < 20; i++) send_beat(ACT_HELLO_LOST, '0, '0, '0);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
        send_beat(ACT_SAMPLE_TICK, '0, '0, '0);
    endtask

    // random action mix, mostly packets with small gaps and sample ticks
    task automatic random_beat();
        int pick;
        logic [23:0] itime;
        pick = $urandom_range(99);
        if (pick < 52) begin
            if ($urandom_range(9) == 0) begin
                seq_cursor = 16'($urandom);
                send_beat(ACT_PACKET, seq_cursor, 24'($urandom), 24'($urandom));
            end else begin
                send_packet_inc($urandom_range(0, 4));
            end
        end else if (pick < 76) begin
            send_beat(ACT_SAMPLE_TICK, 16'($urandom), 24'($urandom), 24'($urandom));
        end else if (pick < 86) begin
            send_beat(ACT_HELLO_LOST, 16'($urandom), 24'($urandom), 24'($urandom));
        end else if (pick < 92) begin
            itime = ($urandom_range(1) == 0) ? 24'd0 : 24'($urandom);
            send_beat(ACT_LINK_CHANGED, 16'($urandom), itime, 24'($urandom));
        end else if (pick < 96) begin
            send_beat(ACT_LINK_INIT, 16'($urandom), 24'($urandom), 24'($urandom));
        end else begin
            send_beat(3'($urandom_range(5, 7)), 16'($urandom), 24'($urandom),
                      24'($urandom));
        end
    endtask

    task automatic test_random();
        int cfgs [6][4];
        cfgs = '{'{64, 4, 1000, 65536},
                 '{2, 1, 100, 4096},
                 '{256, 256, 3600000, 16777215},
                 '{0, 0, 0, 0},
                 '{511, 511, 4194303, 200000},
                 '{17, 300, 2500, 9000}};
        for (int p = 0; p < 6; p++) begin
            write_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
            idle_pct = (p < 2) ? 22 : (p < 4) ? 46 : 0;
            for (int i = 0; i < 200; i++) random_beat();
        end
        idle_pct = 0;
    endtask

    // compare each cost beat with the oldest expected cost
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (cost_q.size() == 0) begin
                $display("%0t: unexpected cost beat, expected none, got %0d",
                         $time, o_link_cost);
                err_cnt++;
            end else begin
                if (o_link_cost !== cost_q[0]) begin
                    $display("%0t: link_cost mismatch, expected %0d, got %0d",
                             $time, cost_q[0], o_link_cost);
                    err_cnt++;
                end
                void'(cost_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        clear_link_state();
        for (int i = 0; i < WIN_MAX; i++) tot_cnt[i] = 1;
        cur_win = START_WIN_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_random();
        drain();
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/etx_pkg.sv
src/etx_ram.sv
src/etx_alu.sv
src/etx_link_cost_estimator_unit.sv
test/tb_etx_link_cost_estimator_unit.sv
